// ===== src/nfa_regex_matcher_macros.svh =====
// ----------------------------------------------------------------------------
// nfa_regex_matcher_macros : assertion macros for the NFA matcher
// Concurrent checks on clk_i, quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef NFA_REGEX_MATCHER_MACROS_SVH
`define NFA_REGEX_MATCHER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge out of reset
`define NRM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent
`define NRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define NRM_ASSERT(label, prop, msg)
`define NRM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== src/nrm_pkg.sv =====
// ----------------------------------------------------------------------------
// nrm_pkg : shared types and constants of the NFA matcher
// Payload structs, command encoding, sizing constants and the state decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package nrm_pkg;

  // Sizing
  localparam int unsigned MAX_STATES      = 64;
  localparam int unsigned MAX_TRANSITIONS = 128;
  localparam int unsigned QUEUE_DEPTH     = 2;

  // Fixed field widths
  localparam int unsigned STATE_W = 6;
  localparam int unsigned INDEX_W = 7;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned COUNT_W = 8;

  // Derived widths
  localparam int unsigned TAB_ADDR_W = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
  localparam int unsigned SCAN_W     = $clog2(MAX_TRANSITIONS + 1);
  localparam int unsigned QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [1:0]  REG_START  = 2'd0;
  localparam logic [1:0]  REG_ACCEPT = 2'd1;
  localparam logic [1:0]  REG_IN_USE = 2'd2;

  // Input opcodes
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_BEGIN   = 2'd1;
  localparam logic [1:0] OP_CONSUME = 2'd2;

  typedef logic [MAX_STATES-1:0] state_set_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_BEGIN,
    CMD_CONSUME
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [INDEX_W-1:0] entry_index;
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic [SYM_W-1:0]   symbol_byte;
    logic               is_epsilon;
    logic               last_symbol;
  } in_t;

  typedef struct packed {
    logic accepted;
    logic final_res;
  } out_t;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [TAB_ADDR_W-1:0] entry_index;
    logic [STATE_W-1:0]    from_state;
    logic [STATE_W-1:0]    to_state;
    logic [SYM_W-1:0]      symbol_byte;
    logic                  is_epsilon;
    logic                  last_symbol;
  } cmd_t;

  typedef struct packed {
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic [SYM_W-1:0]   symbol_byte;
    logic               is_epsilon;
  } entry_t;

  typedef struct packed {
    logic [STATE_W-1:0] start_state;
    logic [STATE_W-1:0] accept_state;
    logic [COUNT_W-1:0] transitions_in_use;
  } cfg_t;

  // One-hot set bit of a state; empty for a state beyond MAX_STATES
  function automatic state_set_t state_bit(input logic [STATE_W-1:0] s);
    state_set_t res;
    for (int unsigned j = 0; j < MAX_STATES; j++) begin
      res[j] = (32'(s) == j);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/nfa_regex_matcher.sv =====
// ----------------------------------------------------------------------------
// nfa_regex_matcher : Thompson NFA simulation with epsilon closure
// Loads a transition table, then runs the active state set over a text one
// character per transaction and reports whether the accept state is active.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                          Moves
//  -------   ------------------------------   ------------------------------
//  input     in_valid_i / in_ready_o          load, begin or consume command
//  output    out_valid_o / out_ready_i        accepted flag and end-of-text
//  config    psel/penable/pwrite/paddr/...    start, accept, entries in use
//
//  A table pass reads the n entries in use in turn, paced by the single
//  read port of the transition table. A begin takes p closure passes, a
//  consume one character pass plus p closure passes (p >= 1, one more than
//  the passes that still grow the set); a load writes one entry. Reset
//  clears the active set and the registers; the table holds nothing valid
//  until loaded. A two-entry command queue keeps accepting while a scan
//  runs, and the result register holds one result.
//
`default_nettype none

`include "nfa_regex_matcher_macros.svh"

module nfa_regex_matcher (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  nrm_pkg::in_t                         in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output nrm_pkg::out_t                        out_data_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [nrm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [nrm_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [nrm_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                 pready
);

  nrm_pkg::cfg_t cfg_q;
  logic          cfg_we;
  logic          push, q_full, q_empty, pop;
  nrm_pkg::cmd_t push_cmd, pop_cmd;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_state        <= '0;
      cfg_q.accept_state       <= nrm_pkg::STATE_W'(1);
      cfg_q.transitions_in_use <= '0;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        nrm_pkg::REG_START:  cfg_q.start_state        <= pwdata[nrm_pkg::STATE_W-1:0];
        nrm_pkg::REG_ACCEPT: cfg_q.accept_state       <= pwdata[nrm_pkg::STATE_W-1:0];
        nrm_pkg::REG_IN_USE: cfg_q.transitions_in_use <= pwdata[nrm_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read back
  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      nrm_pkg::REG_START:  prdata = nrm_pkg::CFG_DATA_W'(cfg_q.start_state);
      nrm_pkg::REG_ACCEPT: prdata = nrm_pkg::CFG_DATA_W'(cfg_q.accept_state);
      nrm_pkg::REG_IN_USE: prdata = nrm_pkg::CFG_DATA_W'(cfg_q.transitions_in_use);
      default:             prdata = '0;
    endcase
  end

  nrm_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .full_i     (q_full)
  );

  nrm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (q_empty)
  );

  nrm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (!q_empty),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Checks on the queue between front and back
  `NRM_ASSERT(a_no_push_when_full, !(push && q_full), "command pushed into a full queue")
  `NRM_ASSERT(a_no_pop_when_empty, !(pop && q_empty), "command popped from an empty queue")
  `NRM_ASSERT_NEXT(a_push_fills, push && !pop, !q_empty, "queue empty after a push")

endmodule

`default_nettype wire

// ===== src/nrm_queue.sv =====
// ----------------------------------------------------------------------------
// nrm_queue : command queue between front and back
// Small FIFO of decoded commands; lets either side stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module nrm_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  nrm_pkg::cmd_t      push_cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output nrm_pkg::cmd_t      pop_cmd_o,
  output logic               empty_o
);

  localparam int unsigned DEPTH = nrm_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = nrm_pkg::QPTR_W;
  localparam int unsigned CW    = nrm_pkg::QCNT_W;

  nrm_pkg::cmd_t slot_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o    = (count_q == CW'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign pop_cmd_o = slot_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/nrm_front.sv =====
// ----------------------------------------------------------------------------
// nrm_front : input side of the NFA matcher
// Accepts input transactions, decodes the opcode and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module nrm_front (
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  nrm_pkg::in_t  in_data_i,
  output logic          push_o,
  output nrm_pkg::cmd_t push_cmd_o,
  input  wire logic     full_i
);

  localparam int unsigned AW = nrm_pkg::TAB_ADDR_W;

  logic keep;
  logic slot_ok;

  assign in_ready_o = !full_i;
  assign slot_ok    = (32'(in_data_i.entry_index) < nrm_pkg::MAX_TRANSITIONS);

  // Classify: drop unused opcodes and loads outside the table
  always_comb begin
    keep                   = 1'b0;
    push_cmd_o.kind        = nrm_pkg::CMD_LOAD;
    push_cmd_o.entry_index = AW'(in_data_i.entry_index);
    push_cmd_o.from_state  = in_data_i.from_state;
    push_cmd_o.to_state    = in_data_i.to_state;
    push_cmd_o.symbol_byte = in_data_i.symbol_byte;
    push_cmd_o.is_epsilon  = in_data_i.is_epsilon;
    push_cmd_o.last_symbol = in_data_i.last_symbol;
    unique case (in_data_i.opcode)
      nrm_pkg::OP_LOAD: begin
        keep            = slot_ok;
        push_cmd_o.kind = nrm_pkg::CMD_LOAD;
      end
      nrm_pkg::OP_BEGIN: begin
        keep            = 1'b1;
        push_cmd_o.kind = nrm_pkg::CMD_BEGIN;
      end
      nrm_pkg::OP_CONSUME: begin
        keep            = 1'b1;
        push_cmd_o.kind = nrm_pkg::CMD_CONSUME;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = in_valid_i && in_ready_o && keep;

endmodule

`default_nettype wire

// ===== src/nrm_back.sv =====
// ----------------------------------------------------------------------------
// nrm_back : execution side of the NFA matcher
// Holds the transition table and the active set; scans the table one entry
// a cycle for the character step and for each epsilon-closure pass.
// ----------------------------------------------------------------------------
`default_nettype none

module nrm_back (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  nrm_pkg::cfg_t cfg_i,
  input  wire logic     cmd_valid_i,
  input  nrm_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output nrm_pkg::out_t out_data_o
);

  localparam int unsigned AW = nrm_pkg::TAB_ADDR_W;
  localparam int unsigned SW = nrm_pkg::SCAN_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e                         state_q;
  logic                           eps_phase_q;
  logic [SW-1:0]                  addr_q;
  logic                           rd_vld_q, rd_last_q;
  logic                           grew_q;
  nrm_pkg::state_set_t            work_q, active_q;
  logic [nrm_pkg::SYM_W-1:0]      sym_q;
  logic                           last_q;
  logic                           out_valid_q;
  nrm_pkg::out_t                  out_q;

  nrm_pkg::entry_t                mem_q [nrm_pkg::MAX_TRANSITIONS];
  nrm_pkg::entry_t                rd_q;
  nrm_pkg::entry_t                wr_entry;

  logic [SW-1:0]                  n_lim;
  logic [SW-1:0]                  next_addr;
  logic                           rd_en, mem_we;
  nrm_pkg::state_set_t            src_bit, dst_bit, work_upd;
  logic                           char_hit, eps_hit, pass_end, grew_now, out_free;

  // Scan count, saturated at the table depth
  assign n_lim = (32'(cfg_i.transitions_in_use) > nrm_pkg::MAX_TRANSITIONS)
                 ? SW'(nrm_pkg::MAX_TRANSITIONS) : SW'(cfg_i.transitions_in_use);

  assign pop_o     = (state_q == ST_IDLE) && cmd_valid_i;
  assign mem_we    = pop_o && (cmd_i.kind == nrm_pkg::CMD_LOAD);
  assign rd_en     = (state_q == ST_SCAN) && (addr_q < n_lim);
  assign next_addr = addr_q + SW'(1);

  assign wr_entry.from_state  = cmd_i.from_state;
  assign wr_entry.to_state    = cmd_i.to_state;
  assign wr_entry.symbol_byte = cmd_i.symbol_byte;
  assign wr_entry.is_epsilon  = cmd_i.is_epsilon;

  // Transition table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cmd_i.entry_index] <= wr_entry;
    end
    if (rd_en) begin
      rd_q <= mem_q[addr_q[AW-1:0]];
    end
  end

  // Evaluate the entry that has just been read
  always_comb begin
    src_bit  = nrm_pkg::state_bit(rd_q.from_state);
    dst_bit  = nrm_pkg::state_bit(rd_q.to_state);
    char_hit = rd_vld_q && !rd_q.is_epsilon && (rd_q.symbol_byte == sym_q)
               && |(src_bit & active_q);
    eps_hit  = rd_vld_q && rd_q.is_epsilon && |(src_bit & work_q)
               && |dst_bit && !(|(dst_bit & work_q));
    work_upd = work_q;
    if (eps_phase_q ? eps_hit : char_hit) begin
      work_upd = work_q | dst_bit;
    end
    grew_now = grew_q || eps_hit;
    pass_end = (n_lim == '0) || (rd_vld_q && rd_last_q);
    out_free = !out_valid_q || out_ready_i;
  end

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      eps_phase_q <= 1'b0;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      grew_q      <= 1'b0;
      work_q      <= '0;
      active_q    <= '0;
      sym_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      rd_vld_q  <= rd_en;
      rd_last_q <= rd_en && (next_addr == n_lim);
      // Load a fresh result, or drop the one just taken
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            addr_q <= '0;
            grew_q <= 1'b0;
            sym_q  <= cmd_i.symbol_byte;
            last_q <= cmd_i.last_symbol;
            case (cmd_i.kind)
              nrm_pkg::CMD_BEGIN: begin
                work_q      <= nrm_pkg::state_bit(cfg_i.start_state);
                eps_phase_q <= 1'b1;
                state_q     <= ST_SCAN;
              end
              nrm_pkg::CMD_CONSUME: begin
                work_q      <= '0;
                eps_phase_q <= 1'b0;
                state_q     <= ST_SCAN;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_SCAN: begin
          work_q <= work_upd;
          // Close a pass: go on to closure, repeat it, or finish
          if (pass_end) begin
            addr_q <= '0;
            grew_q <= 1'b0;
            if (!eps_phase_q) begin
              eps_phase_q <= 1'b1;
            end else if (!grew_now) begin
              state_q <= ST_DONE;
            end
          end else begin
            if (rd_en) begin
              addr_q <= next_addr;
            end
            if (eps_phase_q) begin
              grew_q <= grew_now;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_q.accepted    <= |(work_q & nrm_pkg::state_bit(cfg_i.accept_state));
            out_q.final_res   <= last_q;
            active_q          <= work_q;
            state_q           <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
